>>> hw/rtl/rrmt_pkg.sv
// ----------------------------------------------------------------------------
// rrmt_pkg
// Shared types and constants for the range-add / range-minimum tree.
// ----------------------------------------------------------------------------
package rrmt_pkg;

   localparam int DATA_W     = 32;
   localparam int FIELD_W    = 6;
   localparam int DEF_LEAVES = 64;

   localparam logic [FIELD_W-1:0]        LAST_RESET = 6'd63;
   localparam logic signed [DATA_W-1:0]  EMPTY_MIN  = 32'sh7FFF_FFFF;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_BUILD = 2'd1,
      OP_ADD   = 2'd2,
      OP_QUERY = 2'd3
   } op_type;

   typedef logic signed [DATA_W-1:0] data_type;

   function automatic data_type smin(input data_type a, input data_type b);
      return (a < b) ? a : b;
   endfunction

endpackage

>>> hw/rtl/rrmt_ram.sv
// ----------------------------------------------------------------------------
// rrmt_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rrmt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/range_add_range_min_tree.sv
// ----------------------------------------------------------------------------
// range_add_range_min_tree
// Lazy segment tree over signed 32-bit values: leaf load, build, range add
// and range minimum, one item at a time.
// ----------------------------------------------------------------------------
// The tree lives in two node RAMs (minimum and pending add) plus a leaf RAM,
// and a sequencer walks it depth first with a small return stack. Each
// visited node passes through a read, an evaluate and a decide state, and
// through two push states when a pending add is pushed to its children; each
// return passes through the return state. An add or a query touches up to
// about four nodes per level, at most about 23 nodes at 64 leaves. A build
// visits all 2*(last_index+1)-1 nodes. A load is written to the leaf RAM as
// it is accepted.
// After reset a clearing pass over all 2**(clog2(LEAVES)+1) entries zeroes the
// pending-add RAM before the first item is taken.
module range_add_range_min_tree
   import rrmt_pkg::*;
#(
   parameter int LEAVES = DEF_LEAVES
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [rrmt_pkg::FIELD_W-1:0] csr_wr_data,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_op,
   input  logic [rrmt_pkg::FIELD_W-1:0] req_range_low,
   input  logic [rrmt_pkg::FIELD_W-1:0] req_range_high,
   input  logic signed [rrmt_pkg::DATA_W-1:0] req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [rrmt_pkg::DATA_W-1:0] rsp_minimum,
   output logic                         rsp_empty_res
);

   localparam int IW    = $clog2(LEAVES);
   localparam int NW    = IW + 1;
   localparam int NODES = 2 ** NW;
   localparam int XW    = ((IW > FIELD_W) ? IW : FIELD_W) + 1;
   localparam int SD    = IW + 1;
   localparam int SIW   = $clog2(SD);
   localparam int SPW   = $clog2(SD + 1);

   typedef enum logic [7:0] {
      ST_CLR  = 8'b0000_0001,
      ST_IDLE = 8'b0000_0010,
      ST_RD   = 8'b0000_0100,
      ST_EV   = 8'b0000_1000,
      ST_C1   = 8'b0001_0000,
      ST_C2   = 8'b0010_0000,
      ST_DEC  = 8'b0100_0000,
      ST_RET  = 8'b1000_0000
   } state_type;

   // FIN is folded into a flag so the state set stays small
   state_type         state_ff, state_in;
   logic              fin_ff, fin_in;
   logic [NW-1:0]     clr_ff, clr_in;
   logic [FIELD_W-1:0] last_ff, last_in;
   op_type            op_ff, op_in;
   logic [IW-1:0]     qlo_ff, qlo_in, qhi_ff, qhi_in;
   data_type          val_ff, val_in;
   logic [IW-1:0]     lo_ff, lo_in, hi_ff, hi_in;
   logic [NW-1:0]     node_ff, node_in;
   logic [SPW-1:0]    sp_ff, sp_in;
   data_type          ret_ff, ret_in;
   data_type          acc_ff, acc_in;
   logic              emp_ff, emp_in;
   data_type          delta_ff, delta_in;
   logic              desc_ff, desc_in;
   logic              rsp_valid_ff, rsp_valid_in;
   data_type          rsp_min_ff, rsp_min_in;
   logic              rsp_emp_ff, rsp_emp_in;

   logic [IW-1:0]     stk_lo_ff [SD];
   logic [IW-1:0]     stk_hi_ff [SD];
   data_type          stk_left_ff [SD];

   // memory ports
   logic              leaf_we;
   logic [IW-1:0]     leaf_wa, leaf_ra;
   data_type          leaf_rd;
   logic              nmin_we;
   logic [NW-1:0]     nmin_wa;
   data_type          nmin_wd, nmin_rd;
   logic              pend_we;
   logic [NW-1:0]     pend_wa, pend_ra;
   data_type          pend_wd, pend_rd;

   logic [XW-1:0]     last_x, qlo_x, qhi_x;
   logic [IW-1:0]     last_i, mid;
   logic [IW:0]       lo_hi_sum;
   logic [NW-1:0]     child0, child1;
   logic [SIW-1:0]    push_idx, top_idx;
   logic              accept, is_build, is_query, leaf, out_rng, full;
   data_type          m, vadd, res;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign is_build  = (op_ff == OP_BUILD);
   assign is_query  = (op_ff == OP_QUERY);

   // clamp of last_index to the leaf count and of the range high end to last_index
   assign last_x = (XW'(last_ff) > XW'(LEAVES - 1)) ? XW'(LEAVES - 1) : XW'(last_ff);
   assign last_i = last_x[IW-1:0];
   assign qlo_x  = XW'(req_range_low);
   assign qhi_x  = (XW'(req_range_high) > last_x) ? last_x : XW'(req_range_high);

   assign lo_hi_sum = (IW+1)'(lo_ff) + (IW+1)'(hi_ff);
   assign mid       = lo_hi_sum[IW:1];
   assign child0    = {node_ff[NW-2:0], 1'b0};
   assign child1    = {node_ff[NW-2:0], 1'b1};
   assign push_idx  = SIW'(sp_ff);
   assign top_idx   = SIW'(sp_ff - 1'b1);

   assign leaf    = (lo_ff == hi_ff);
   assign out_rng = (lo_ff > qhi_ff) || (hi_ff < qlo_ff);
   assign full    = (qlo_ff <= lo_ff) && (hi_ff <= qhi_ff);
   assign m       = nmin_rd + pend_rd;
   assign vadd    = (full && (op_ff == OP_ADD)) ? val_ff : '0;
   assign res     = smin(stk_left_ff[top_idx], ret_ff);

   // memory addressing
   assign leaf_we = accept && (req_op == OP_LOAD) && (qlo_x < XW'(LEAVES));
   assign leaf_wa = qlo_x[IW-1:0];
   assign leaf_ra = lo_ff;

   always_comb begin
      pend_ra = node_ff;
      case (state_ff)
         ST_EV:   pend_ra = child0;
         ST_C1:   pend_ra = child1;
         default: pend_ra = node_ff;
      endcase
   end

   always_comb begin
      pend_we = 1'b0;
      pend_wa = node_ff;
      pend_wd = '0;
      nmin_we = 1'b0;
      nmin_wa = node_ff;
      nmin_wd = m + vadd;
      case (state_ff)
         ST_CLR: begin
            pend_we = 1'b1;
            pend_wa = clr_ff;
         end
         ST_EV: begin
            pend_we = 1'b1;
            if (is_build) begin
               nmin_we = leaf;
               nmin_wd = leaf_rd;
            end else begin
               nmin_we = 1'b1;
            end
         end
         ST_C1: begin
            pend_we = 1'b1;
            pend_wa = child0;
            pend_wd = pend_rd + delta_ff;
         end
         ST_C2: begin
            pend_we = 1'b1;
            pend_wa = child1;
            pend_wd = pend_rd + delta_ff;
         end
         ST_RET: begin
            nmin_we = !is_query && (sp_ff != '0) && node_ff[0];
            nmin_wa = node_ff >> 1;
            nmin_wd = res;
         end
         default: begin
            pend_we = 1'b0;
         end
      endcase
   end

   rrmt_ram #(.WIDTH(DATA_W), .DEPTH(LEAVES)) u_leaf_ram (
      .clock   (clock),
      .wr_en   (leaf_we),
      .wr_addr (leaf_wa),
      .wr_data (req_value),
      .rd_addr (leaf_ra),
      .rd_data (leaf_rd)
   );

   rrmt_ram #(.WIDTH(DATA_W), .DEPTH(NODES)) u_nmin_ram (
      .clock   (clock),
      .wr_en   (nmin_we),
      .wr_addr (nmin_wa),
      .wr_data (nmin_wd),
      .rd_addr (node_ff),
      .rd_data (nmin_rd)
   );

   rrmt_ram #(.WIDTH(DATA_W), .DEPTH(NODES)) u_pend_ram (
      .clock   (clock),
      .wr_en   (pend_we),
      .wr_addr (pend_wa),
      .wr_data (pend_wd),
      .rd_addr (pend_ra),
      .rd_data (pend_rd)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      fin_in   = fin_ff;
      clr_in   = clr_ff;
      last_in  = csr_wr_en ? csr_wr_data : last_ff;
      op_in    = op_ff;
      qlo_in   = qlo_ff;
      qhi_in   = qhi_ff;
      val_in   = val_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      node_in  = node_ff;
      sp_in    = sp_ff;
      ret_in   = ret_ff;
      acc_in   = acc_ff;
      emp_in   = emp_ff;
      delta_in = delta_ff;
      desc_in  = desc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_min_in   = rsp_min_ff;
      rsp_emp_in   = rsp_emp_ff;

      // a finished query waits here until the output register is free
      if (fin_ff && (!rsp_valid_ff || rsp_ready)) begin
         fin_in       = 1'b0;
         rsp_valid_in = 1'b1;
         rsp_min_in   = acc_ff;
         rsp_emp_in   = emp_ff;
         state_in     = ST_IDLE;
      end

      case (state_ff)
         ST_CLR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               op_in   = op_type'(req_op);
               qlo_in  = qlo_x[IW-1:0];
               qhi_in  = qhi_x[IW-1:0];
               val_in  = req_value;
               lo_in   = '0;
               hi_in   = last_i;
               node_in = NW'(1);
               sp_in   = '0;
               acc_in  = EMPTY_MIN;
               emp_in  = 1'b0;
               case (op_type'(req_op))
                  OP_BUILD: begin
                     state_in = ST_RD;
                  end
                  OP_ADD: begin
                     if (qlo_x <= qhi_x) begin
                        state_in = ST_RD;
                     end
                  end
                  OP_QUERY: begin
                     if (qlo_x <= qhi_x) begin
                        state_in = ST_RD;
                     end else begin
                        emp_in   = 1'b1;
                        fin_in   = 1'b1;
                        state_in = ST_RET;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_RD: begin
            state_in = ST_EV;
         end
         ST_EV: begin
            if (is_build) begin
               ret_in   = leaf_rd;
               desc_in  = !leaf;
               state_in = ST_DEC;
            end else begin
               ret_in   = m + vadd;
               delta_in = pend_rd + vadd;
               desc_in  = !out_rng && !full;
               if (is_query && full) begin
                  acc_in = smin(acc_ff, m);
               end
               state_in = (!leaf && ((pend_rd + vadd) != '0)) ? ST_C1 : ST_DEC;
            end
         end
         ST_C1: begin
            state_in = ST_C2;
         end
         ST_C2: begin
            state_in = ST_DEC;
         end
         ST_DEC: begin
            if (desc_ff) begin
               sp_in    = sp_ff + 1'b1;
               node_in  = child0;
               hi_in    = mid;
               state_in = ST_RD;
            end else begin
               state_in = ST_RET;
            end
         end
         ST_RET: begin
            if (fin_ff) begin
               state_in = fin_in ? ST_RET : ST_IDLE;
            end else if (sp_ff == '0) begin
               if (is_query) begin
                  fin_in = 1'b1;
               end else begin
                  state_in = ST_IDLE;
               end
            end else if (!node_ff[0]) begin
               // left child done, go to its sibling
               node_in  = node_ff | NW'(1);
               lo_in    = hi_ff + 1'b1;
               hi_in    = stk_hi_ff[top_idx];
               state_in = ST_RD;
            end else begin
               ret_in  = res;
               node_in = node_ff >> 1;
               lo_in   = stk_lo_ff[top_idx];
               hi_in   = stk_hi_ff[top_idx];
               sp_in   = sp_ff - 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR;
         fin_ff       <= 1'b0;
         clr_ff       <= '0;
         last_ff      <= LAST_RESET;
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fin_ff       <= fin_in;
         clr_ff       <= clr_in;
         last_ff      <= last_in;
         sp_ff        <= sp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      qlo_ff     <= qlo_in;
      qhi_ff     <= qhi_in;
      val_ff     <= val_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      node_ff    <= node_in;
      ret_ff     <= ret_in;
      acc_ff     <= acc_in;
      emp_ff     <= emp_in;
      delta_ff   <= delta_in;
      desc_ff    <= desc_in;
      rsp_min_ff <= rsp_min_in;
      rsp_emp_ff <= rsp_emp_in;
      if (state_ff == ST_DEC && desc_ff) begin
         stk_lo_ff[push_idx] <= lo_ff;
         stk_hi_ff[push_idx] <= hi_ff;
      end
      if (state_ff == ST_RET && !fin_ff && sp_ff != '0 && !node_ff[0]) begin
         stk_left_ff[top_idx] <= ret_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_minimum   = rsp_min_ff;
   assign rsp_empty_res = rsp_emp_ff;

endmodule

>>> bench/tb_range_add_range_min_tree.sv
// ----------------------------------------------------------------------------
// tb_range_add_range_min_tree
// Self-checking bench for the lazy range-add / range-minimum tree: a queued
// driver, a response monitor and a scoreboard fed by a behavioral tree model.
// ----------------------------------------------------------------------------
module tb_range_add_range_min_tree;
   timeunit 1ns;
   timeprecision 1ps;
   import rrmt_pkg::*;

   typedef struct {
      op_type           op;
      logic [5:0]       lo;
      logic [5:0]       hi;
      logic [31:0]      val;
      bit               is_cfg;
   } tree_cmd_type;

   typedef struct {
      logic [31:0] minimum;
      logic        empty_res;
   } min_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [5:0]  csr_wr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_op = '0;
   logic [5:0]  req_range_low = '0;
   logic [5:0]  req_range_high = '0;
   logic signed [31:0] req_value = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic signed [31:0] rsp_minimum;
   logic        rsp_empty_res;

   range_add_range_min_tree uut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_ready(req_ready), .req_op(req_op),
      .req_range_low(req_range_low), .req_range_high(req_range_high),
      .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_minimum(rsp_minimum), .rsp_empty_res(rsp_empty_res)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // model state
   logic [31:0] mdl_leaf [64];
   logic [31:0] mdl_node [256];
   logic [31:0] mdl_lazy [256];
   int          mdl_last = 63;

   tree_cmd_type   pending_cmds[$];
   min_result_type expected_mins[$];
   int          mismatches = 0;
   bit          quiet_tail = 1'b0;
   int          accepted = 0;

   function automatic logic [31:0] smin32(logic [31:0] a, logic [31:0] b);
      return ($signed(a) < $signed(b)) ? a : b;
   endfunction

   function automatic void build_tree(int lo, int hi, int nd);
      int mid;
      mdl_lazy[nd] = 0;
      if (lo == hi) begin
         mdl_node[nd] = mdl_leaf[lo];
         return;
      end
      mid = (lo + hi) / 2;
      build_tree(lo, mid, 2 * nd);
      build_tree(mid + 1, hi, 2 * nd + 1);
      mdl_node[nd] = smin32(mdl_node[2 * nd], mdl_node[2 * nd + 1]);
   endfunction

   function automatic void push_lazy(int lo, int hi, int nd);
      logic [31:0] p;
      p = mdl_lazy[nd];
      if (p != 0) begin
         mdl_node[nd] += p;
         if (lo != hi) begin
            mdl_lazy[2 * nd] += p;
            mdl_lazy[2 * nd + 1] += p;
         end
         mdl_lazy[nd] = 0;
      end
   endfunction

   function automatic void add_range(int lo, int hi, int ql, int qh, int nd,
                                     logic [31:0] v);
      int mid;
      push_lazy(lo, hi, nd);
      if (lo > qh || hi < ql) return;
      if (ql <= lo && hi <= qh) begin
         mdl_node[nd] += v;
         if (lo != hi) begin
            mdl_lazy[2 * nd] += v;
            mdl_lazy[2 * nd + 1] += v;
         end
         return;
      end
      mid = (lo + hi) / 2;
      add_range(lo, mid, ql, qh, 2 * nd, v);
      add_range(mid + 1, hi, ql, qh, 2 * nd + 1, v);
      mdl_node[nd] = smin32(mdl_node[2 * nd], mdl_node[2 * nd + 1]);
   endfunction

   function automatic logic [31:0] min_range(int lo, int hi, int ql, int qh, int nd);
      int mid;
      logic [31:0] a, b;
      push_lazy(lo, hi, nd);
      if (lo > qh || hi < ql) return 32'h7FFF_FFFF;
      if (ql <= lo && hi <= qh) return mdl_node[nd];
      mid = (lo + hi) / 2;
      a = min_range(lo, mid, ql, qh, 2 * nd);
      b = min_range(mid + 1, hi, ql, qh, 2 * nd + 1);
      return smin32(a, b);
   endfunction

   function automatic void predict_tree_op(tree_cmd_type c);
      int ql, qh;
      min_result_type r;
      ql = c.lo;
      qh = c.hi;
      case (c.op)
         OP_LOAD:  mdl_leaf[ql] = c.val;
         OP_BUILD: build_tree(0, mdl_last, 1);
         default: begin
            if (qh > mdl_last) qh = mdl_last;
            if (c.op == OP_ADD) begin
               if (ql <= qh) add_range(0, mdl_last, ql, qh, 1, c.val);
            end else begin
               if (ql > qh) begin
                  r.minimum = 32'h7FFF_FFFF;
                  r.empty_res = 1'b1;
               end else begin
                  r.minimum = min_range(0, mdl_last, ql, qh, 1);
                  r.empty_res = 1'b0;
               end
               expected_mins.push_back(r);
            end
         end
      endcase
   endfunction

   // ---- stimulus construction
   function automatic logic [31:0] rand_value();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return $urandom_range(0, 20) - 10;
         default: return $urandom;
      endcase
   endfunction

   function automatic void queue_op(op_type op, int lo, int hi, logic [31:0] v);
      tree_cmd_type c;
      c.op = op; c.lo = 6'(lo); c.hi = 6'(hi); c.val = v; c.is_cfg = 1'b0;
      pending_cmds.push_back(c);
   endfunction

   function automatic void queue_cfg(int last);
      tree_cmd_type c;
      c.op = OP_LOAD; c.lo = 6'(last); c.hi = '0; c.val = '0; c.is_cfg = 1'b1;
      pending_cmds.push_back(c);
   endfunction

   function automatic void queue_full_load(int n);
      for (int i = 0; i < n; i++) queue_op(OP_LOAD, i, 0, rand_value());
      queue_op(OP_BUILD, $urandom_range(0, 63), $urandom_range(0, 63), $urandom);
   endfunction

   function automatic void queue_random_phase(int n);
      int k, lo, hi;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(0, 99);
         lo = $urandom_range(0, 63);
         hi = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                          : lo + $urandom_range(0, 63 - lo);
         if (k < 40) queue_op(OP_QUERY, lo, hi, $urandom);
         else if (k < 80) queue_op(OP_ADD, lo, hi, rand_value());
         else if (k < 95) queue_op(OP_LOAD, $urandom_range(0, 63), $urandom, rand_value());
         else queue_op(OP_BUILD, lo, hi, $urandom);
      end
   endfunction

   // ---- driver
   int  req_gap = 0;
   int  rsp_gap = 0;
   tree_cmd_type cur;
   bit  have_cur = 1'b0;

   always @(posedge clock) begin
      csr_wr_en <= 1'b0;
      if (!reset) begin
         if (req_valid && req_ready) begin
            accepted++;
            have_cur = 1'b0;
         end
         if (!have_cur && pending_cmds.size() > 0 && req_gap == 0) begin
            if (pending_cmds[0].is_cfg) begin
               // only touch the register once the block is idle and drained
               if (!req_valid && req_ready && expected_mins.size() == 0) begin
                  cur = pending_cmds.pop_front();
                  mdl_last = cur.lo;
                  csr_wr_en <= 1'b1;
                  csr_wr_data <= cur.lo;
               end
               req_valid <= 1'b0;
            end else begin
               cur = pending_cmds.pop_front();
               have_cur = 1'b1;
               predict_tree_op(cur);
               req_valid <= 1'b1;
               req_op <= cur.op;
               req_range_low <= cur.lo;
               req_range_high <= cur.hi;
               req_value <= cur.val;
            end
         end else if (!have_cur) begin
            req_valid <= 1'b0;
            if (req_gap > 0) req_gap--;
            else if (!quiet_tail && $urandom_range(0, 7) == 0)
               req_gap = $urandom_range(1, 12);
         end
         if (have_cur == 1'b0 && req_gap == 0 && !quiet_tail && $urandom_range(0, 9) == 0)
            req_gap = $urandom_range(1, 12);
         // response back-pressure
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_ready <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
            rsp_gap = $urandom_range(1, 12);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ---- monitor / scoreboard
   always @(posedge clock) begin
      min_result_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_mins.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: minimum %0d empty %0b",
                        rsp_minimum, rsp_empty_res);
         end else begin
            e = expected_mins.pop_front();
            if (rsp_minimum !== e.minimum || rsp_empty_res !== e.empty_res) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected minimum %0d empty %0b, got %0d %0b",
                           $signed(e.minimum), e.empty_res, rsp_minimum, rsp_empty_res);
            end
         end
      end
   end

   // ---- watchdog: cycles with no transfer on either side
   int idle_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      int lasts[6];
      lasts = '{0, 63, 1, 17, 32, 63};
      // directed: extremes and special cases on the full tree
      queue_full_load(64);
      queue_op(OP_QUERY, 0, 63, 0);
      queue_op(OP_QUERY, 5, 5, 0);
      queue_op(OP_QUERY, 9, 3, 0);             // reversed range
      queue_op(OP_ADD, 7, 2, 32'h1234);        // reversed add is a no-op
      queue_op(OP_ADD, 0, 63, 32'h7FFF_FFFF);  // wraps
      queue_op(OP_ADD, 10, 40, 32'h8000_0000);
      queue_op(OP_QUERY, 0, 63, 0);
      queue_op(OP_QUERY, 40, 41, 0);
      queue_op(OP_LOAD, 63, 63, 32'hFFFF_FFFF);
      queue_op(OP_BUILD, 0, 0, 0);
      queue_op(OP_QUERY, 63, 63, 0);
      queue_op(OP_QUERY, 0, 62, 0);
      // configuration sweep, with a shape change before rebuilding
      foreach (lasts[i]) begin
         queue_cfg(lasts[i]);
         queue_op(OP_QUERY, lasts[i] + 1, 63, 0);  // beyond the end (wraps to the full range when last is 63)
         queue_random_phase(20);
         queue_full_load(lasts[i] + 1);
         queue_op(OP_QUERY, 0, 63, 0);
         queue_random_phase(120);
      end
      wait (pending_cmds.size() < 120);
      quiet_tail = 1'b1;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      wait (pending_cmds.size() == 0 && !have_cur);
      wait (expected_mins.size() == 0);
      repeat (300) @(posedge clock);
      if (mismatches == 0 && expected_mins.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end
endmodule
